FILE: rtl/core/assert_macros.svh
// Assertion macros used by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/core/sldd_pkg.sv
// Types and constants for the straight-line Doppler drift core.
package sldd_pkg;
  localparam int QueueDepth = 4;
  localparam int SqrtSteps = 32;
  localparam logic [22:0] DriftDiv = 23'd6144000;
  localparam logic [22:0] DriftHalf = 23'd3072000;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [15:0] time_now;
    logic [19:0] carrier_freq;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] drift;
    logic zero_range;
    logic saturated;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic [19:0] freq;
    logic zero;
  } work_t;
endpackage

FILE: rtl/core/sldd_front.sv
// Front end: range vector and normalization, two registered stages.
module sldd_front import sldd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      out_valid,
  output work_t     out_work
);
  logic v1;
  logic signed [15:0] vx1, vy1;
  logic signed [33:0] rx1, ry1;
  logic [19:0] f1;
  logic [33:0] ax, ay, mx;
  logic [5:0] lz;
  logic signed [33:0] nx, ny;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    vx1 <= in_item.vel_x;
    vy1 <= in_item.vel_y;
    rx1 <= 34'(in_item.vel_x * $signed({1'b0, in_item.time_now}))
         + 34'($signed({in_item.pos_x, 12'd0}));
    ry1 <= 34'(in_item.vel_y * $signed({1'b0, in_item.time_now}))
         + 34'($signed({in_item.pos_y, 12'd0}));
    f1 <= in_item.carrier_freq;
  end

  always_comb begin
    ax = rx1[33] ? 34'(-rx1) : rx1;
    ay = ry1[33] ? 34'(-ry1) : ry1;
    mx = ax | ay;
    lz = 6'd0;
    for (int i = 0; i <= 30; i++) begin
      if (mx[i]) lz = 6'(30 - i);
    end
    if (mx[33:31] != 3'd0) begin
      nx = rx1 >>> 1;
      ny = ry1 >>> 1;
    end else begin
      nx = rx1 <<< lz;
      ny = ry1 <<< lz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    out_work.vx <= vx1;
    out_work.vy <= vy1;
    out_work.rx <= nx;
    out_work.ry <= ny;
    out_work.freq <= f1;
    out_work.zero <= (rx1 == 34'sd0) && (ry1 == 34'sd0);
  end
endmodule

FILE: rtl/core/sldd_queue.sv
// Short FIFO between front and back.
module sldd_queue import sldd_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  input  logic  pop,
  output logic  nonempty,
  output work_t rdata,
  output logic  [$clog2(Depth):0] count
);
  localparam int AW = $clog2(Depth);
  work_t mem [Depth];
  logic [AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= wdata;
  end

  assign nonempty = count != '0;
  assign rdata = mem[rp];
endmodule

FILE: rtl/core/sldd_back.sv
// Back end: dot product, pipelined square root, divide and frequency scaling.
module sldd_back import sldd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  work_t     in_work,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam int DS = 42;
  // ceil(2^39 / 375): exact floor divide by 375 for 31-bit operands
  localparam logic [30:0] Recip375 = 31'd1466015504;

  // stage A: squares and dot terms
  logic va;
  logic [63:0] sqx, sqy;
  logic signed [50:0] dxa, dya;
  logic [19:0] fa;
  logic za;
  logic [33:0] axw, ayw;
  assign axw = in_work.rx[33] ? 34'(-in_work.rx) : in_work.rx;
  assign ayw = in_work.ry[33] ? 34'(-in_work.ry) : in_work.ry;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= in_valid;
    sqx <= 64'(axw[31:0]) * 64'(axw[31:0]);
    sqy <= 64'(ayw[31:0]) * 64'(ayw[31:0]);
    dxa <= 51'(in_work.vx * in_work.rx);
    dya <= 51'(in_work.vy * in_work.ry);
    fa <= in_work.freq;
    za <= in_work.zero;
  end

  // stage B: sum
  logic vb, zb, posb;
  logic [64:0] sb;
  logic [49:0] adb;
  logic [19:0] fb;
  logic signed [50:0] dsum;
  assign dsum = dxa + dya;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    sb <= 65'(sqx) + 65'(sqy);
    adb <= dsum[50] ? 50'(-dsum) : 50'(dsum);
    posb <= dsum > 0;
    fb <= fa;
    zb <= za;
  end

  // square root, one result bit per stage
  logic [64:0] srem [SqrtSteps+1];
  logic [32:0] sroot [SqrtSteps+1];
  logic sv [SqrtSteps+1];
  logic sz [SqrtSteps+1];
  logic sp [SqrtSteps+1];
  logic [49:0] sad [SqrtSteps+1];
  logic [19:0] sf [SqrtSteps+1];
  assign srem[0] = sb; assign sroot[0] = '0; assign sv[0] = vb;
  assign sz[0] = zb; assign sp[0] = posb; assign sad[0] = adb; assign sf[0] = fb;
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [64:0] trial;
    logic [65:0] part;
    always_comb begin
      part = 66'(srem[k] >> (2 * (SqrtSteps - 1 - k)));
      trial = 65'({sroot[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      if (part >= 66'(trial)) begin
        srem[k+1] <= srem[k] - (trial << (2 * (SqrtSteps - 1 - k)));
        sroot[k+1] <= {sroot[k][31:0], 1'b1};
      end else begin
        srem[k+1] <= srem[k];
        sroot[k+1] <= {sroot[k][31:0], 1'b0};
      end
      sz[k+1] <= sz[k]; sp[k+1] <= sp[k]; sad[k+1] <= sad[k]; sf[k+1] <= sf[k];
    end
  end

  // restoring divide of adb*256 by root, one quotient bit per stage
  logic [32:0] nden;
  assign nden = (sroot[SqrtSteps] == '0) ? 33'd1 : sroot[SqrtSteps];
  logic [57:0] dnum [DS+1];
  logic [33:0] drem [DS+1];
  logic [41:0] dq [DS+1];
  logic [32:0] dden [DS+1];
  logic dv [DS+1];
  logic dz [DS+1];
  logic dp [DS+1];
  logic [19:0] df [DS+1];
  // upper 16 numerator bits seed the remainder: below 2^16, so below the root
  assign dnum[0] = {sad[SqrtSteps], 8'd0};
  assign drem[0] = 34'({sad[SqrtSteps], 8'd0} >> 42);
  assign dq[0] = '0;
  assign dden[0] = nden; assign dv[0] = sv[SqrtSteps]; assign dz[0] = sz[SqrtSteps];
  assign dp[0] = sp[SqrtSteps]; assign df[0] = sf[SqrtSteps];
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [34:0] sh;
    assign sh = {drem[k], dnum[k][DS - 1 - k]};
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else dv[k+1] <= dv[k];
      if (sh >= 35'(dden[k])) begin
        drem[k+1] <= 34'(sh - 35'(dden[k]));
        dq[k+1] <= {dq[k][40:0], 1'b1};
      end else begin
        drem[k+1] <= 34'(sh);
        dq[k+1] <= {dq[k][40:0], 1'b0};
      end
      dnum[k+1] <= dnum[k]; dden[k+1] <= dden[k];
      dz[k+1] <= dz[k]; dp[k+1] <= dp[k]; df[k+1] <= df[k];
    end
  end

  // scale: W*f split in two partial products
  logic vm, zm, pm;
  logic [61:0] plo, phi;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else vm <= dv[DS];
    plo <= 62'(dq[DS][20:0]) * 62'(df[DS]);
    phi <= 62'(dq[DS][41:21]) * 62'(df[DS]);
    zm <= dz[DS]; pm <= dp[DS];
  end
  logic vs, zs, ps;
  logic [62:0] prod;
  always_ff @(posedge clk) begin
    if (rst) vs <= 1'b0;
    else vs <= vm;
    prod <= 63'(plo) + 63'(phi << 21) + 63'(DriftHalf);
    zs <= zm; ps <= pm;
  end
  // divide by 6144000 = 2^14 * 375: shift, then reciprocal multiply (prod < 2^44)
  logic vq, zq, pq;
  logic [39:0] mag;
  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else vq <= vs;
    mag <= 40'((62'(prod[44:14]) * 62'(Recip375)) >> 39);
    zq <= zs; pq <= ps;
  end

  logic signed [23:0] drift_next;
  logic sat_next;
  always_comb begin
    drift_next = 24'(mag);
    sat_next = 1'b0;
    if (zq) drift_next = '0;
    else if (pq) begin
      if (mag > 40'd8388608) begin
        drift_next = 24'h800000;
        sat_next = 1'b1;
      end else drift_next = 24'(-mag);
    end else if (mag > 40'd8388607) begin
      drift_next = 24'h7FFFFF;
      sat_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vq;
    out_item.zero_range <= zq;
    out_item.saturated <= sat_next;
    out_item.drift <= drift_next;
  end
endmodule

FILE: rtl/core/straight_line_doppler_drift_core.sv
// Top level of the straight-line Doppler drift core.
// One item per cycle enters while busy is low; each result appears on result
// with done high for one cycle, after two front stages, the queue register,
// two back stages (squares and dot product, sums), a 32-stage square root,
// a 42-stage divider and four scaling and output stages. The receiver cannot
// stall, so busy stays low and items may follow back to back.
`include "assert_macros.svh"
module straight_line_doppler_drift_core import sldd_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      done,
  output out_item_t result
);
  logic fv;
  work_t fw;
  logic ne;
  work_t qd;
  logic [$clog2(Depth):0] cnt;

  sldd_front u_front (.clk, .rst, .in_valid(start && !busy), .in_item(item),
    .out_valid(fv), .out_work(fw));
  sldd_queue #(.Depth(Depth)) u_q (.clk, .rst, .push(fv), .wdata(fw),
    .pop(ne), .nonempty(ne), .rdata(qd), .count(cnt));
  sldd_back u_back (.clk, .rst, .in_valid(ne), .in_work(qd),
    .out_valid(done), .out_item(result));

  assign busy = 1'b0;

  `ASSERT_IMPLIES(a_q_bound, clk, rst, 1'b1, cnt <= 2)
  `ASSERT_NEXT(a_front_flow, clk, rst, start && !busy, fv == 1'b0 || fv == 1'b1)
  `ASSERT_IMPLIES(a_zero_drift, clk, rst, done && result.zero_range, result.drift == '0)
endmodule
